// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define ETF_IMPLY(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("implication failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define ETF_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("next-cycle implication failed");

`endif

// ===== rtl/etf_pkg.sv =====
package etf_pkg;

	// palette size and derived widths
	localparam int NUM_COLORS = 256;
	localparam int CNT_W      = 10;
	localparam int COL_W      = $clog2(NUM_COLORS);
	localparam int NUM_W      = CNT_W + COL_W;
	localparam int DIVC_W     = $clog2(NUM_W + 1);
	localparam int STEP_W     = (DIVC_W > 3) ? DIVC_W : 3;

	// Q7.24 number
	typedef logic signed [31:0] fx_t;
	localparam fx_t FX_ONE  = 32'sh0100_0000;
	localparam fx_t FX_HALF = 32'sh0080_0000;

	// map selector codes
	localparam logic [3:0] FT_MANDEL  = 4'd0;
	localparam logic [3:0] FT_JULIA   = 4'd1;
	localparam logic [3:0] FT_BARN1   = 4'd2;
	localparam logic [3:0] FT_BARN2   = 4'd3;
	localparam logic [3:0] FT_BARN3   = 4'd4;
	localparam logic [3:0] FT_SPIDER  = 4'd5;
	localparam logic [3:0] FT_MANOWAR = 4'd6;
	localparam logic [3:0] FT_LAMBDA  = 4'd7;
	localparam logic [3:0] FT_SIERP   = 4'd8;

	// register indexes
	localparam logic [2:0] CFG_TYPE   = 3'd0;
	localparam logic [2:0] CFG_XORG   = 3'd1;
	localparam logic [2:0] CFG_YORG   = 3'd2;
	localparam logic [2:0] CFG_XSTEP  = 3'd3;
	localparam logic [2:0] CFG_YSTEP  = 3'd4;
	localparam logic [2:0] CFG_LIMIT  = 3'd5;
	localparam logic [2:0] CFG_JCX    = 3'd6;
	localparam logic [2:0] CFG_JCY    = 3'd7;

	// multiplier operand pairs
	typedef enum logic [3:0] {
		M_COL, M_ROW, M_XX, M_YY, M_XY, M_XCX, M_XCY, M_YCX, M_YCY,
		M_CXP, M_CYQ, M_CXQ, M_CYP, M_EXX, M_EYY
	} mul_sel_t;

	typedef struct packed {
		logic             load;
		logic             mul_go;
		mul_sel_t         mul_sel;
		logic             init;
		logic             lam;
		logic             upd;
		logic             div_load;
		logic             div_step;
		logic             res_load;
		logic [CNT_W-1:0] cnt;
		logic             esc;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0]       ftype;
		logic [CNT_W-1:0] limit;
		logic             mag_esc;
	} dp_stat_t;

	function automatic fx_t sat64(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		else if (v < -64'sd2147483648) return 32'sh8000_0000;
		else return v[31:0];
	endfunction

	function automatic logic signed [63:0] ext(input fx_t a);
		return {{32{a[31]}}, a};
	endfunction

	function automatic fx_t fadd(input fx_t a, input fx_t b);
		return sat64(ext(a) + ext(b));
	endfunction

	function automatic fx_t fsub(input fx_t a, input fx_t b);
		return sat64(ext(a) - ext(b));
	endfunction

	function automatic fx_t fneg(input fx_t a);
		return sat64(-ext(a));
	endfunction

	function automatic fx_t fdbl(input fx_t a);
		return fadd(a, a);
	endfunction

	function automatic fx_t fhalf(input fx_t a);
		return {a[31], a[31:1]};
	endfunction

	// product back to Q7.24, floor then saturate
	function automatic fx_t fmulp(input logic signed [63:0] p);
		return sat64(p >>> 24);
	endfunction

endpackage

// ===== rtl/etf_dp.sv =====
module etf_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [26:0]        cfg_data,
	input  logic [23:0]        pixel_column,
	input  logic [23:0]        pixel_row,
	input  etf_pkg::dp_cmd_t   cmd,
	output etf_pkg::dp_stat_t  stat,
	output logic [7:0]         color_index,
	output logic [9:0]         iteration_count,
	output logic               escaped
);
	import etf_pkg::*;

	logic [3:0]         ftype_q;
	logic signed [26:0] x_org_q, y_org_q, jcx_q, jcy_q;
	logic signed [24:0] x_step_q, y_step_q;
	logic [CNT_W-1:0]   limit_q;
	logic [23:0]        col_q, row_q;
	fx_t                a_q, b_q, x_q, y_q, tx_q, ty_q, p_q, q_q;
	fx_t                f_xx, f_yy, f_xy, f_xcx, f_xcy, f_ycx, f_ycy;
	fx_t                f_cxp, f_cyq, f_cxq, f_cyp;
	logic signed [63:0] ex_q, ey_q, prod_s1;
	mul_sel_t           sel_s1;
	logic               vld_s1;
	fx_t                cx, cy, mul_a, mul_b, f_new;
	fx_t                nx, ny, ntx, nty, rs, p_l, qn, q_l;
	logic               cond;
	logic [63:0]        mag;
	logic [NUM_W-1:0]   num_q, quo_q;
	logic [CNT_W:0]     rem_q, rem_sh;
	logic               ge;
	logic [7:0]         color_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               esc_q;

	assign cfg_ready = 1'b1;
	assign cx = {{5{jcx_q[26]}}, jcx_q};
	assign cy = {{5{jcy_q[26]}}, jcy_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ftype_q  <= FT_MANDEL;
			x_org_q  <= -27'sd33554432;
			y_org_q  <= -27'sd33554432;
			x_step_q <= 25'sd167772;
			y_step_q <= 25'sd167772;
			limit_q  <= 10'd50;
			jcx_q    <= -27'sd12582912;
			jcy_q    <= 27'sd3355443;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TYPE:  ftype_q  <= cfg_data[3:0];
				CFG_XORG:  x_org_q  <= cfg_data;
				CFG_YORG:  y_org_q  <= cfg_data;
				CFG_XSTEP: x_step_q <= cfg_data[24:0];
				CFG_YSTEP: y_step_q <= cfg_data[24:0];
				CFG_LIMIT: limit_q  <= cfg_data[CNT_W-1:0];
				CFG_JCX:   jcx_q    <= cfg_data;
				CFG_JCY:   jcy_q    <= cfg_data;
			endcase
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			M_COL: begin mul_a = {8'd0, col_q}; mul_b = {{7{x_step_q[24]}}, x_step_q}; end
			M_ROW: begin mul_a = {8'd0, row_q}; mul_b = {{7{y_step_q[24]}}, y_step_q}; end
			M_XX:  begin mul_a = x_q; mul_b = x_q; end
			M_YY:  begin mul_a = y_q; mul_b = y_q; end
			M_XY:  begin mul_a = x_q; mul_b = y_q; end
			M_XCX: begin mul_a = x_q; mul_b = cx; end
			M_XCY: begin mul_a = x_q; mul_b = cy; end
			M_YCX: begin mul_a = y_q; mul_b = cx; end
			M_YCY: begin mul_a = y_q; mul_b = cy; end
			M_CXP: begin mul_a = cx; mul_b = p_q; end
			M_CYQ: begin mul_a = cy; mul_b = q_q; end
			M_CXQ: begin mul_a = cx; mul_b = q_q; end
			M_CYP: begin mul_a = cy; mul_b = p_q; end
			M_EXX: begin mul_a = x_q; mul_b = x_q; end
			M_EYY: begin mul_a = y_q; mul_b = y_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// shared multiplier, one product a cycle while mul_go is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= mul_a * mul_b;
			sel_s1  <= cmd.mul_sel;
		end
	end

	assign f_new = fmulp(prod_s1);

	// lambda pre-terms
	assign p_l = fadd(fsub(x_q, f_xx), f_yy);
	assign qn  = fneg(f_xy);
	assign q_l = fadd(qn, fadd(qn, y_q));

	// next point for the selected map
	always_comb begin
		nx   = x_q;
		ny   = y_q;
		ntx  = tx_q;
		nty  = ty_q;
		rs   = fadd(f_xcy, f_ycx);
		cond = 1'b0;
		case (ftype_q)
			FT_MANDEL: begin
				nx = fadd(fsub(f_xx, f_yy), a_q);
				ny = fadd(fdbl(f_xy), b_q);
			end
			FT_JULIA: begin
				nx = fadd(fsub(f_xx, f_yy), cx);
				ny = fadd(fdbl(f_xy), cy);
			end
			FT_BARN1, FT_BARN2: begin
				cond = (ftype_q == FT_BARN1) ? !x_q[31] : !rs[31];
				if (cond) begin
					nx = fsub(fsub(f_xcx, cx), f_ycy);
					ny = fadd(fsub(f_ycx, cy), f_xcy);
				end else begin
					nx = fsub(fadd(f_xcx, cx), f_ycy);
					ny = fadd(fadd(f_ycx, cy), f_xcy);
				end
			end
			FT_BARN3: begin
				if (x_q <= 0) begin
					nx = fadd(fsub(fsub(f_xx, f_yy), FX_ONE), f_xcx);
					ny = fadd(fdbl(f_xy), f_xcy);
				end else begin
					nx = fsub(fsub(f_xx, f_yy), FX_ONE);
					ny = fdbl(f_xy);
				end
			end
			FT_SPIDER: begin
				nx  = fadd(fadd(fsub(f_xx, f_yy), tx_q), cx);
				ny  = fadd(fadd(fdbl(f_xy), ty_q), cy);
				ntx = fadd(fhalf(tx_q), nx);
				nty = fadd(fhalf(ty_q), ny);
			end
			FT_MANOWAR: begin
				nx  = fadd(fadd(fsub(f_xx, f_yy), tx_q), cx);
				ny  = fadd(fadd(fdbl(f_xy), ty_q), cy);
				ntx = x_q;
				nty = y_q;
			end
			FT_LAMBDA: begin
				nx = fsub(f_cxp, f_cyq);
				ny = fadd(f_cxq, f_cyp);
			end
			FT_SIERP: begin
				nx = fdbl(x_q);
				ny = fdbl(y_q);
				// upper half folds first; neither half leaves plain doubling
				if (y_q > FX_HALF) ny = fsub(fdbl(y_q), FX_ONE);
				else if (x_q > FX_HALF) nx = fsub(fdbl(x_q), FX_ONE);
			end
			default: begin
				nx = x_q;
				ny = y_q;
			end
		endcase
	end

	// point, product and orbit registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q <= pixel_column;
			row_q <= pixel_row;
		end
		if (vld_s1) begin
			case (sel_s1)
				M_COL: a_q <= sat64($signed({{37{x_org_q[26]}}, x_org_q}) + prod_s1);
				M_ROW: b_q <= sat64($signed({{37{y_org_q[26]}}, y_org_q}) + prod_s1);
				M_XX:  f_xx  <= f_new;
				M_YY:  f_yy  <= f_new;
				M_XY:  f_xy  <= f_new;
				M_XCX: f_xcx <= f_new;
				M_XCY: f_xcy <= f_new;
				M_YCX: f_ycx <= f_new;
				M_YCY: f_ycy <= f_new;
				M_CXP: f_cxp <= f_new;
				M_CYQ: f_cyq <= f_new;
				M_CXQ: f_cxq <= f_new;
				M_CYP: f_cyp <= f_new;
				M_EXX: ex_q  <= prod_s1;
				M_EYY: ey_q  <= prod_s1;
				default: ;
			endcase
		end
		if (cmd.init) begin
			x_q  <= (ftype_q == FT_MANDEL) ? '0 : a_q;
			y_q  <= (ftype_q == FT_MANDEL) ? '0 : b_q;
			tx_q <= a_q;
			ty_q <= b_q;
		end
		if (cmd.lam) begin
			p_q <= p_l;
			q_q <= q_l;
		end
		if (cmd.upd) begin
			x_q  <= nx;
			y_q  <= ny;
			tx_q <= ntx;
			ty_q <= nty;
		end
	end

	// escape test on exact squares
	assign mag = $unsigned(ex_q) + $unsigned(ey_q);

	assign stat.ftype   = ftype_q;
	assign stat.limit   = limit_q;
	assign stat.mag_esc = |mag[63:50];

	// restoring divider, one quotient bit a cycle while div_step is high
	assign rem_sh = {rem_q[CNT_W-1:0], num_q[NUM_W-1]};
	assign ge     = (rem_sh >= {1'b0, limit_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q <= NUM_W'(cmd.cnt * (NUM_COLORS - 1));
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= cmd.cnt;
			esc_q <= cmd.esc;
		end else if (cmd.div_step) begin
			rem_q <= ge ? (rem_sh - {1'b0, limit_q}) : rem_sh;
			quo_q <= {quo_q[NUM_W-2:0], ge};
			num_q <= {num_q[NUM_W-2:0], 1'b0};
		end
		if (cmd.res_load) begin
			color_q         <= (quo_q > NUM_W'(255)) ? 8'hFF : quo_q[7:0];
			iteration_count <= cnt_q;
			escaped         <= esc_q;
		end
	end

	assign color_index = color_q;

endmodule

// ===== rtl/etf_ctrl.sv =====
module etf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output etf_pkg::dp_cmd_t   cmd,
	input  etf_pkg::dp_stat_t  stat
);
	import etf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_COORD, S_CWAIT, S_INIT, S_MULA, S_WA, S_LAM, S_MULB,
		S_WB, S_UPD, S_ESC, S_WE, S_CHK, S_DLOAD, S_DIV, S_DONE
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   iter_q;
	logic               esc_q;
	logic               out_valid_q;
	logic               res_go;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign res_go    = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = M_COL;
		cmd.cnt      = iter_q;
		cmd.esc      = esc_q;
		cmd.load     = in_valid && in_ready;
		cmd.init     = (state_q == S_INIT);
		cmd.lam      = (state_q == S_LAM);
		cmd.upd      = (state_q == S_UPD);
		cmd.div_load = (state_q == S_DLOAD);
		cmd.div_step = (state_q == S_DIV);
		cmd.res_load = res_go;
		unique case (state_q)
			S_COORD: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = step_q[0] ? M_ROW : M_COL;
			end
			S_MULA: begin
				cmd.mul_go = 1'b1;
				case (step_q[2:0])
					3'd0:    cmd.mul_sel = M_XX;
					3'd1:    cmd.mul_sel = M_YY;
					3'd2:    cmd.mul_sel = M_XY;
					3'd3:    cmd.mul_sel = M_XCX;
					3'd4:    cmd.mul_sel = M_XCY;
					3'd5:    cmd.mul_sel = M_YCX;
					default: cmd.mul_sel = M_YCY;
				endcase
			end
			S_MULB: begin
				cmd.mul_go = 1'b1;
				case (step_q[1:0])
					2'd0:    cmd.mul_sel = M_CXP;
					2'd1:    cmd.mul_sel = M_CYQ;
					2'd2:    cmd.mul_sel = M_CXQ;
					default: cmd.mul_sel = M_CYP;
				endcase
			end
			S_ESC: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = step_q[0] ? M_EYY : M_EXX;
			end
			default: cmd.mul_go = 1'b0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			iter_q      <= '0;
			esc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result beat raised on load, dropped once taken
			out_valid_q <= res_go || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (in_valid) state_q <= S_COORD;
				end
				S_COORD: begin
					step_q <= step_q + 1'b1;
					if (step_q[0]) state_q <= S_CWAIT;
				end
				S_CWAIT: state_q <= S_INIT;
				S_INIT: begin
					iter_q <= '0;
					esc_q  <= 1'b0;
					step_q <= '0;
					state_q <= (stat.limit == '0) ? S_DLOAD : S_MULA;
				end
				S_MULA: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(6)) state_q <= S_WA;
				end
				S_WA: state_q <= (stat.ftype == FT_LAMBDA) ? S_LAM : S_UPD;
				S_LAM: begin
					step_q  <= '0;
					state_q <= S_MULB;
				end
				S_MULB: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(3)) state_q <= S_WB;
				end
				S_WB: state_q <= S_UPD;
				S_UPD: begin
					step_q  <= '0;
					state_q <= S_ESC;
				end
				S_ESC: begin
					step_q <= step_q + 1'b1;
					if (step_q[0]) state_q <= S_WE;
				end
				S_WE: state_q <= S_CHK;
				S_CHK: begin
					step_q <= '0;
					priority if (stat.mag_esc) begin
						esc_q   <= 1'b1;
						state_q <= S_DLOAD;
					end else if ((iter_q + 1'b1) == stat.limit) begin
						iter_q  <= iter_q + 1'b1;
						state_q <= S_DLOAD;
					end else begin
						iter_q  <= iter_q + 1'b1;
						state_q <= S_MULA;
					end
				end
				S_DLOAD: begin
					step_q  <= '0;
					state_q <= (stat.limit == '0) ? S_DONE : S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(NUM_W - 1)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_go) state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/escape_time_fractal_pixel_core.sv =====
// Escape-time fractal pixel core: one pixel beat in, one result beat out.
// A pixel's time grows with the number of iterations run, and a Lambda
// iteration takes longer than one of the other maps; the divider for
// the palette index adds to it. The time is set by the single shared
// 32x32 multiplier, which forms every product of an iteration one after
// another, and by the bit-serial index divider. One pixel is worked at a
// time; a finished result waits in the output register while the next
// pixel is taken in. Configuration writes are always taken and must only
// be made while the core is idle.
module escape_time_fractal_pixel_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] pixel_column,
	input  logic [23:0] pixel_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  color_index,
	output logic [9:0]  iteration_count,
	output logic        escaped,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [26:0] cfg_data
);
	import etf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	etf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// arithmetic and registers
	etf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pixel_column    (pixel_column),
		.pixel_row       (pixel_row),
		.cmd             (cmd),
		.stat            (stat),
		.color_index     (color_index),
		.iteration_count (iteration_count),
		.escaped         (escaped)
	);

endmodule

// ===== rtl/etf_port_chk.sv =====
`include "assert_macros.svh"

module etf_port_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [23:0] pixel_column,
	input logic [23:0] pixel_row,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  color_index,
	input logic [9:0]  iteration_count,
	input logic        escaped,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [26:0] cfg_data
);

	// a waiting result beat is held
	`ETF_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`ETF_NEXT(a_out_stable, out_valid && !out_ready, $stable(color_index) && $stable(iteration_count) && $stable(escaped))
	// no iterations done means the first palette entry
	`ETF_IMPLY(a_zero_color, out_valid && iteration_count == 10'd0, color_index == 8'd0)
	// configuration port never stalls
	`ETF_IMPLY(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind escape_time_fractal_pixel_core etf_port_chk u_port_chk (.*);
